>>> hw/rtl/sha1_pkg.sv
// Shared constants, control structs, round functions and the padding helper of the SHA-1 core.
package sha1_pkg;

    localparam int BLOCK_WORDS = 16;
    localparam int CHAIN_WORDS = 5;
    localparam int ROUNDS      = 80;

    localparam logic [31:0] H_INIT [CHAIN_WORDS] = '{
        32'h67452301, 32'hEFCDAB89, 32'h98BADCFE, 32'h10325476, 32'hC3D2E1F0
    };

    localparam logic [31:0] K_R0 = 32'h5A827999;
    localparam logic [31:0] K_R1 = 32'h6ED9EBA1;
    localparam logic [31:0] K_R2 = 32'h8F1BBCDC;
    localparam logic [31:0] K_R3 = 32'hCA62C1D6;

    localparam logic [31:0] PAD_MARK = 32'h80000000;

    // Control toward the block buffer and message schedule.
    typedef struct packed {
        logic        wr_en;
        logic [3:0]  wr_addr;
        logic [31:0] wr_data;
        logic [3:0]  rd_addr;
        logic        shift_load;
        logic        shift_round;
    } sched_ctl_t;

    // Control toward the chaining store and round datapath.
    typedef struct packed {
        logic [2:0]  rd_addr;
        logic        load_var;
        logic        round_en;
        logic [6:0]  round_idx;
        logic        upd_wr;
        logic [2:0]  upd_addr;
        logic        final_blk;
        logic        clear_valid;
    } round_ctl_t;

    function automatic logic [31:0] round_f(logic [6:0] idx, logic [31:0] b,
                                            logic [31:0] c, logic [31:0] d);
        logic [31:0] f;
        if (idx < 7'd20) begin
            f = (b & c) | (~b & d);
        end else if (idx < 7'd40) begin
            f = b ^ c ^ d;
        end else if (idx < 7'd60) begin
            f = (b & c) | (b & d) | (c & d);
        end else begin
            f = b ^ c ^ d;
        end
        return f;
    endfunction

    function automatic logic [31:0] round_k(logic [6:0] idx);
        logic [31:0] k;
        if (idx < 7'd20) begin
            k = K_R0;
        end else if (idx < 7'd40) begin
            k = K_R1;
        end else if (idx < 7'd60) begin
            k = K_R2;
        end else begin
            k = K_R3;
        end
        return k;
    endfunction

    // Keep the valid leading bytes of a short final word and append the marker byte.
    function automatic logic [31:0] pad_last_word(logic [31:0] data, logic [1:0] nb);
        logic [31:0] w;
        case (nb)
            2'd0:    w = PAD_MARK;
            2'd1:    w = {data[31:24], 24'h800000};
            2'd2:    w = {data[31:16], 16'h8000};
            2'd3:    w = {data[31:8], 8'h80};
            default: w = PAD_MARK;
        endcase
        return w;
    endfunction

endpackage

>>> hw/rtl/sha1_channels.sv
// Handshake channels of the SHA-1 core: message words in, digest words out.
interface sha1_in_if;
    logic        valid;
    logic        ready;
    logic [31:0] data_word;
    logic [2:0]  valid_bytes;
    logic        last;

    modport source (output valid, data_word, valid_bytes, last, input ready);
    modport sink   (input valid, data_word, valid_bytes, last, output ready);
endinterface

interface sha1_out_if;
    logic        valid;
    logic        ready;
    logic [31:0] digest_word;
    logic [2:0]  digest_index;
    logic        last_word;

    modport source (output valid, digest_word, digest_index, last_word, input ready);
    modport sink   (input valid, digest_word, digest_index, last_word, output ready);
endinterface

>>> hw/rtl/sha1_hash_core.sv
// Top level of the SHA-1 core: input handling, padding and compression sequencer.
//
//   channel  | dir | payload                                  | handshake
//   ---------+-----+------------------------------------------+------------
//   msg      | in  | data_word[31:0] valid_bytes[2:0] last    | valid/ready
//   digest   | out | digest_word[31:0] digest_index[2:0]      | valid/ready
//            |     | last_word                                |
//
// A message word that is taken is written to the block buffer memory.
// The word that fills a block stalls msg while the buffer memory streams into the
// schedule and the chaining memory is read, the 80 rounds run on one shared round
// unit, and the chaining memory is read, added to and written back.
// A last word adds one padding word per cycle up to the block end and one or two
// compressions.  Reset clears the sequencer and the chaining valid bits at once;
// no clearing pass.  The five digest words sit in an output register, so the next
// message is taken while they drain; only the next final chaining update waits.
module sha1_hash_core import sha1_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    sha1_in_if.sink   msg,
    sha1_out_if.source digest
);

    localparam logic [3:0] LEN_HI_SLOT = 4'd14;
    localparam logic [3:0] LAST_SLOT   = 4'd15;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_PAD,
        ST_LOAD,
        ST_ROUND,
        ST_UPD
    } state_t;

    state_t      state_reg, state_next;
    logic [6:0]  cnt_reg, cnt_next;
    logic [3:0]  fill_reg, fill_next;
    logic [63:0] bitlen_reg, bitlen_next;
    logic        mark_reg, mark_next;     // marker word still to be written
    logic        extra_reg, extra_next;   // no room for the length in this block
    logic        pad_reg, pad_next;       // message end seen, padding in progress
    logic        final_reg, final_next;   // block in flight carries the length

    sched_ctl_t  sc;
    round_ctl_t  rc;
    logic [31:0] w_cur;
    logic        out_busy;
    logic        in_fire;
    logic [2:0]  nbytes;

    assign msg.ready = (state_reg == ST_IDLE);
    assign in_fire   = msg.valid && msg.ready;

    // clamp the byte count of a final word to four
    assign nbytes = (msg.valid_bytes inside {[3'd4:3'd7]}) ? 3'd4 : msg.valid_bytes;

    always_comb
    begin
        state_next  = state_reg;
        cnt_next    = cnt_reg;
        fill_next   = fill_reg;
        bitlen_next = bitlen_reg;
        mark_next   = mark_reg;
        extra_next  = extra_reg;
        pad_next    = pad_reg;
        final_next  = final_reg;

        sc             = '0;
        sc.wr_addr     = fill_reg;
        sc.rd_addr     = cnt_reg[3:0];
        rc             = '0;
        rc.rd_addr     = cnt_reg[2:0];
        rc.round_idx   = cnt_reg;
        rc.upd_addr    = 3'(cnt_reg - 7'd1);
        rc.final_blk   = final_reg;

        case (state_reg)
            ST_IDLE:
            begin
                if (in_fire)
                begin
                    sc.wr_en  = 1'b1;
                    fill_next = fill_reg + 4'd1;
                    pad_next  = msg.last;
                    if (msg.last)
                    begin
                        bitlen_next = bitlen_reg + 64'({nbytes, 3'b000});
                        if (nbytes == 3'd4)
                        begin
                            sc.wr_data = msg.data_word;
                            mark_next  = 1'b1;
                        end
                        else
                        begin
                            sc.wr_data = pad_last_word(msg.data_word, nbytes[1:0]);
                            mark_next  = 1'b0;
                            extra_next = (fill_reg == LEN_HI_SLOT);
                        end
                    end
                    else
                    begin
                        bitlen_next = bitlen_reg + 64'd32;
                        sc.wr_data  = msg.data_word;
                    end
                    if (fill_reg == LAST_SLOT)
                    begin
                        state_next = ST_LOAD;
                        cnt_next   = '0;
                        final_next = 1'b0;
                    end
                    else if (msg.last)
                    begin
                        state_next = ST_PAD;
                    end
                end
            end

            ST_PAD:
            begin
                sc.wr_en  = 1'b1;
                fill_next = fill_reg + 4'd1;
                if (mark_reg)
                begin
                    sc.wr_data = PAD_MARK;
                    mark_next  = 1'b0;
                    extra_next = (fill_reg == LEN_HI_SLOT);
                end
                else if (extra_reg)
                begin
                    sc.wr_data = '0;
                end
                else if (fill_reg == LEN_HI_SLOT)
                begin
                    sc.wr_data = bitlen_reg[63:32];
                end
                else if (fill_reg == LAST_SLOT)
                begin
                    sc.wr_data = bitlen_reg[31:0];
                end
                else
                begin
                    sc.wr_data = '0;
                end
                if (fill_reg == LAST_SLOT)
                begin
                    state_next = ST_LOAD;
                    cnt_next   = '0;
                    final_next = !mark_reg && !extra_reg;
                    extra_next = 1'b0;
                end
            end

            ST_LOAD:
            begin
                // buffer data and chaining data arrive in the cycle after the read
                sc.shift_load = (cnt_reg != 7'd0);
                rc.load_var   = (cnt_reg != 7'd0) && (cnt_reg <= 7'(CHAIN_WORDS));
                cnt_next      = cnt_reg + 7'd1;
                if (cnt_reg == 7'(BLOCK_WORDS))
                begin
                    state_next = ST_ROUND;
                    cnt_next   = '0;
                end
            end

            ST_ROUND:
            begin
                rc.round_en    = 1'b1;
                sc.shift_round = 1'b1;
                cnt_next       = cnt_reg + 7'd1;
                if (cnt_reg == 7'(ROUNDS - 1))
                begin
                    state_next = ST_UPD;
                    cnt_next   = '0;
                end
            end

            ST_UPD:
            begin
                rc.upd_wr = (cnt_reg != 7'd0);
                // hold the final update until the previous digest has drained
                if (!(cnt_reg == 7'd0 && final_reg && out_busy))
                begin
                    cnt_next = cnt_reg + 7'd1;
                end
                if (cnt_reg == 7'(CHAIN_WORDS))
                begin
                    rc.clear_valid = final_reg;
                    cnt_next       = '0;
                    if (final_reg)
                    begin
                        state_next  = ST_IDLE;
                        bitlen_next = '0;
                        pad_next    = 1'b0;
                        final_next  = 1'b0;
                    end
                    else if (pad_reg)
                    begin
                        state_next = ST_PAD;
                    end
                    else
                    begin
                        state_next = ST_IDLE;
                    end
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_IDLE;
            cnt_reg    <= '0;
            fill_reg   <= '0;
            bitlen_reg <= '0;
            mark_reg   <= 1'b0;
            extra_reg  <= 1'b0;
            pad_reg    <= 1'b0;
            final_reg  <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            cnt_reg    <= cnt_next;
            fill_reg   <= fill_next;
            bitlen_reg <= bitlen_next;
            mark_reg   <= mark_next;
            extra_reg  <= extra_next;
            pad_reg    <= pad_next;
            final_reg  <= final_next;
        end
    end

    sha1_sched u_sched (
        .clk   (clk),
        .ctl   (sc),
        .w_cur (w_cur)
    );

    sha1_round u_round (
        .clk      (clk),
        .rst_n    (rst_n),
        .ctl      (rc),
        .w_cur    (w_cur),
        .out_busy (out_busy),
        .digest   (digest)
    );

endmodule

>>> hw/rtl/sha1_sched.sv
// Block buffer memory and 16-word sliding message schedule.
module sha1_sched import sha1_pkg::*;
(
    input  logic        clk,
    input  sched_ctl_t  ctl,
    output logic [31:0] w_cur
);

    logic [31:0] buf_mem [BLOCK_WORDS];
    logic [31:0] rd_q_reg;
    logic [31:0] sched_reg [BLOCK_WORDS];
    logic [31:0] mix;
    logic [31:0] w_new;

    always_ff @(posedge clk)
    begin
        if (ctl.wr_en)
        begin
            buf_mem[ctl.wr_addr] <= ctl.wr_data;
        end
        rd_q_reg <= buf_mem[ctl.rd_addr];
    end

    // w[j+16] = rotl1(w[j+13] ^ w[j+8] ^ w[j+2] ^ w[j])
    assign mix   = sched_reg[13] ^ sched_reg[8] ^ sched_reg[2] ^ sched_reg[0];
    assign w_new = {mix[30:0], mix[31]};

    always_ff @(posedge clk)
    begin
        if (ctl.shift_load || ctl.shift_round)
        begin
            for (int i = 0; i < BLOCK_WORDS - 1; i++)
            begin
                sched_reg[i] <= sched_reg[i + 1];
            end
            sched_reg[BLOCK_WORDS - 1] <= ctl.shift_load ? rd_q_reg : w_new;
        end
    end

    assign w_cur = sched_reg[0];

endmodule

>>> hw/rtl/sha1_round.sv
// Chaining word memory, round datapath and digest output register.
module sha1_round import sha1_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  round_ctl_t  ctl,
    input  logic [31:0] w_cur,
    output logic        out_busy,
    sha1_out_if.source  digest
);

    logic [31:0]            chain_mem [CHAIN_WORDS];
    logic [31:0]            chain_q_reg;
    logic [CHAIN_WORDS-1:0] valid_reg;
    logic [31:0]            a_reg, b_reg, c_reg, d_reg, e_reg;
    logic [31:0]            dig_reg [CHAIN_WORDS];
    logic [2:0]             out_cnt_reg;
    logic [31:0]            t_sum;
    logic [31:0]            upd_sum;
    logic                   out_fire;

    // Entries not yet written since reset or the last digest read as the initial values.
    always_ff @(posedge clk)
    begin
        if (ctl.upd_wr && !ctl.final_blk)
        begin
            chain_mem[ctl.upd_addr] <= upd_sum;
        end
        chain_q_reg <= valid_reg[ctl.rd_addr] ? chain_mem[ctl.rd_addr] : H_INIT[ctl.rd_addr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else if (ctl.clear_valid)
        begin
            valid_reg <= '0;
        end
        else if (ctl.upd_wr && !ctl.final_blk)
        begin
            valid_reg[ctl.upd_addr] <= 1'b1;
        end
    end

    assign t_sum   = {a_reg[26:0], a_reg[31:27]} + round_f(ctl.round_idx, b_reg, c_reg, d_reg)
                   + e_reg + round_k(ctl.round_idx) + w_cur;
    assign upd_sum = chain_q_reg + a_reg;

    always_ff @(posedge clk)
    begin
        if (ctl.load_var)
        begin
            a_reg <= b_reg;
            b_reg <= c_reg;
            c_reg <= d_reg;
            d_reg <= e_reg;
            e_reg <= chain_q_reg;
        end
        else if (ctl.round_en)
        begin
            e_reg <= d_reg;
            d_reg <= c_reg;
            c_reg <= {b_reg[1:0], b_reg[31:2]};
            b_reg <= a_reg;
            a_reg <= t_sum;
        end
        else if (ctl.upd_wr)
        begin
            // bring the next working variable to the adder
            a_reg <= b_reg;
            b_reg <= c_reg;
            c_reg <= d_reg;
            d_reg <= e_reg;
        end
    end

    assign out_fire = digest.valid && digest.ready;

    always_ff @(posedge clk)
    begin
        if (ctl.upd_wr && ctl.final_blk)
        begin
            for (int i = 0; i < CHAIN_WORDS - 1; i++)
            begin
                dig_reg[i] <= dig_reg[i + 1];
            end
            dig_reg[CHAIN_WORDS - 1] <= upd_sum;
        end
        else if (out_fire)
        begin
            for (int i = 0; i < CHAIN_WORDS - 1; i++)
            begin
                dig_reg[i] <= dig_reg[i + 1];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_cnt_reg <= '0;
        end
        else if (ctl.clear_valid)
        begin
            out_cnt_reg <= 3'(CHAIN_WORDS);
        end
        else if (out_fire)
        begin
            out_cnt_reg <= out_cnt_reg - 3'd1;
        end
    end

    assign out_busy            = (out_cnt_reg != 3'd0);
    assign digest.valid        = out_busy;
    assign digest.digest_word  = dig_reg[0];
    assign digest.digest_index = 3'(CHAIN_WORDS) - out_cnt_reg;
    assign digest.last_word    = (out_cnt_reg == 3'd1);

endmodule

>>> hw/rtl/sha1_chk.sv
// Port-level assertions of the SHA-1 core and their binding to the top level.
module sha1_chk
(
    input logic        clk,
    input logic        rst_n,
    input logic        in_valid,
    input logic        in_ready,
    input logic        in_last,
    input logic        out_valid,
    input logic        out_ready,
    input logic [31:0] digest_word,
    input logic [2:0]  digest_index,
    input logic        last_word
);

    logic in_fire;
    logic out_fire;

    assign in_fire  = in_valid && in_ready;
    assign out_fire = out_valid && out_ready;

    // a digest taken short of its fifth word is followed by the next word
    a_digest_seq: assert property (@(posedge clk) disable iff (!rst_n)
        out_fire && !last_word |=> out_valid && digest_index == $past(digest_index) + 3'd1)
        else $error("digest words out of sequence");

    // a fresh digest starts at its most significant word
    a_digest_start: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !$past(out_valid) |-> digest_index == 3'd0 && !last_word)
        else $error("digest does not start at word zero");

    // the final word of a message always leads into padding work
    a_pad_stall: assert property (@(posedge clk) disable iff (!rst_n)
        in_fire && in_last |=> !in_ready)
        else $error("item taken during padding");

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(digest_word))
        else $error("stalled digest word changed");

endmodule

bind sha1_hash_core sha1_chk u_chk (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (msg.valid),
    .in_ready     (msg.ready),
    .in_last      (msg.last),
    .out_valid    (digest.valid),
    .out_ready    (digest.ready),
    .digest_word  (digest.digest_word),
    .digest_index (digest.digest_index),
    .last_word    (digest.last_word)
);

>>> verif/tb_sha1_hash_core.sv
// Testbench for sha1_hash_core: directed and random messages checked against a SHA-1 predictor.
module tb_sha1_hash_core;
    timeunit 1ns;
    timeprecision 1ps;

    // SHA-1 starting chain value and the padding marker byte in word position.
    localparam logic [31:0] CHAIN_IV [5] = '{
        32'h67452301, 32'hEFCDAB89, 32'h98BADCFE, 32'h10325476, 32'hC3D2E1F0
    };
    localparam logic [31:0] MARKER_WORD  = 32'h8000_0000;
    localparam int          IDLE_PCT     = 31;
    localparam int          RANDOM_ITEMS = 280;
    // A final word can still trigger two compressions.
    localparam int          DRAIN_CYCLES = 300;
    localparam int          WAIT_LIMIT   = 50000;

    typedef struct packed {
        logic [31:0] word;
        logic [2:0]  index;
        logic        tail;
    } digest_t;

    logic clk   = 1'b0;
    logic rst_n = 1'b0;

    sha1_in_if  msg_ch ();
    sha1_out_if dig_ch ();

    sha1_hash_core u_dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .msg    (msg_ch),
        .digest (dig_ch)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    int errors = 0;
    // While set, neither side idles: gives a stretch at full rate.
    bit quiet  = 1'b0;

    // Predictor state: chaining words, block buffer, fill count, message length.
    logic [31:0] chain_h [5];
    logic [31:0] blk_words [16];
    logic [3:0]  blk_fill;
    logic [63:0] msg_bits;

    // Digest words still owed by the block, oldest first.
    digest_t digest_queue [$];

    function automatic logic [31:0] rotl32(input logic [31:0] x, input int unsigned n);
        return (x << n) | (x >> (32 - n));
    endfunction

    // Return to the start of a fresh message.
    task automatic sha1_restart();
        for (int i = 0; i < 5; i++)
        begin
            chain_h[i] = CHAIN_IV[i];
        end
        for (int i = 0; i < 16; i++)
        begin
            blk_words[i] = '0;
        end
        blk_fill = '0;
        msg_bits = '0;
    endtask

    // Run the 80 SHA-1 rounds over the full buffer and fold into the chain.
    task automatic sha1_compress_block();
        logic [31:0] sched [80];
        logic [31:0] a, b, c, d, e, f, k, t;
        for (int j = 0; j < 16; j++)
        begin
            sched[j] = blk_words[j];
        end
        for (int j = 16; j < 80; j++)
        begin
            sched[j] = rotl32(sched[j-3] ^ sched[j-8] ^ sched[j-14] ^ sched[j-16], 1);
        end
        a = chain_h[0];
        b = chain_h[1];
        c = chain_h[2];
        d = chain_h[3];
        e = chain_h[4];
        for (int j = 0; j < 80; j++)
        begin
            if (j < 20)
            begin
                f = (b & c) | (~b & d);
                k = 32'h5A827999;
            end
            else if (j < 40)
            begin
                f = b ^ c ^ d;
                k = 32'h6ED9EBA1;
            end
            else if (j < 60)
            begin
                f = (b & c) | (b & d) | (c & d);
                k = 32'h8F1BBCDC;
            end
            else
            begin
                f = b ^ c ^ d;
                k = 32'hCA62C1D6;
            end
            t = rotl32(a, 5) + f + e + k + sched[j];
            e = d;
            d = c;
            c = rotl32(b, 30);
            b = a;
            a = t;
        end
        chain_h[0] += a;
        chain_h[1] += b;
        chain_h[2] += c;
        chain_h[3] += d;
        chain_h[4] += e;
    endtask

    // Store one word; compress when it completes a block.
    task automatic sha1_absorb_word(input logic [31:0] w);
        blk_words[blk_fill] = w;
        blk_fill = blk_fill + 4'd1;
        if (blk_fill == 4'd0)
        begin
            sha1_compress_block();
        end
    endtask

    // Advance the predictor by one accepted item; on a final word, pad,
    // finish the message and queue the five digest words.
    task automatic sha1_predict_item(input logic [31:0] data, input logic [2:0] nbytes,
                                     input logic fin);
        logic [2:0]  nb;
        logic [31:0] mask;
        logic [31:0] w;
        if (!fin)
        begin
            // Byte count is ignored on a word that is not the last.
            sha1_absorb_word(data);
            msg_bits += 64'd32;
            return;
        end
        nb = (nbytes > 3'd4) ? 3'd4 : nbytes;
        msg_bits += 64'(nb) * 64'd8;
        if (nb == 3'd4)
        begin
            sha1_absorb_word(data);
            sha1_absorb_word(MARKER_WORD);
        end
        else
        begin
            // Zero the bytes past the count and place the marker right after them.
            mask = (nb == 3'd0) ? 32'h0 : (32'hFFFF_FFFF << (32 - 8 * nb));
            w    = (data & mask) | (32'h80 << (24 - 8 * nb));
            sha1_absorb_word(w);
        end
        // No room left for the length: close this block with zeros first.
        if (blk_fill > 4'd14)
        begin
            while (blk_fill != 4'd0)
            begin
                sha1_absorb_word('0);
            end
        end
        while (blk_fill < 4'd14)
        begin
            sha1_absorb_word('0);
        end
        sha1_absorb_word(msg_bits[63:32]);
        sha1_absorb_word(msg_bits[31:0]);
        for (int i = 0; i < 5; i++)
        begin
            digest_queue.push_back('{word: chain_h[i], index: 3'(i), tail: (i == 4)});
        end
        sha1_restart();
    endtask

    // Offer one item, idling at random beforehand; return at the accepting edge.
    // Valid stays high on return so a back-to-back item needs no re-raise.
    task automatic send_word(input logic [31:0] data, input logic [2:0] nbytes,
                             input logic fin);
        while (!quiet && ($urandom_range(99) < IDLE_PCT))
        begin
            msg_ch.valid <= 1'b0;
            @(posedge clk);
        end
        msg_ch.valid       <= 1'b1;
        msg_ch.data_word   <= data;
        msg_ch.valid_bytes <= nbytes;
        msg_ch.last        <= fin;
        do
        begin
            @(posedge clk);
        end
        while (!msg_ch.ready);
        sha1_predict_item(data, nbytes, fin);
    endtask

    function automatic logic [31:0] pick_data();
        int unsigned r;
        r = $urandom_range(9);
        if (r == 0)
        begin
            return 32'h0;
        end
        if (r == 1)
        begin
            return 32'hFFFF_FFFF;
        end
        return $urandom;
    endfunction

    // Zero-length message: a final word with no valid bytes.
    task automatic test_empty_message();
        send_word(32'hFFFF_FFFF, 3'd0, 1'b1);
    endtask

    // One-word messages over byte counts one to seven, including counts above four.
    task automatic test_final_byte_counts();
        for (int n = 1; n < 8; n++)
        begin
            send_word((n % 2) ? 32'hFFFF_FFFF : 32'hA5C3_5A3C, 3'(n), 1'b1);
        end
    endtask

    // Non-final words with byte counts other than four still count as four bytes.
    task automatic test_ignored_byte_counts();
        send_word(32'h0000_0000, 3'd0, 1'b0);
        send_word(32'hFFFF_FFFF, 3'd7, 1'b0);
        send_word(32'h1234_5678, 3'd3, 1'b0);
        send_word(32'h8000_0001, 3'd4, 1'b1);
    endtask

    // The classic three-byte "abc" message.
    task automatic test_short_text();
        send_word(32'h6162_6300, 3'd3, 1'b1);
    endtask

    // Random messages biased toward lengths that land the padding near a
    // block end, so the one- and two-block padding paths both get exercised.
    task automatic test_random_messages();
        int sent;
        int msg_idx;
        int len;
        int unsigned r;
        sent    = 0;
        msg_idx = 0;
        while (sent < RANDOM_ITEMS)
        begin
            r = $urandom_range(99);
            if (r < 35)
            begin
                len = $urandom_range(4, 1);
            end
            else if (r < 75)
            begin
                len = $urandom_range(17, 13);
            end
            else if (r < 90)
            begin
                len = $urandom_range(33, 29);
            end
            else
            begin
                len = $urandom_range(40, 5);
            end
            quiet = (msg_idx >= 10) && (msg_idx < 16);
            for (int i = 0; i < len - 1; i++)
            begin
                send_word(pick_data(), ($urandom_range(99) < 80) ? 3'd4 : 3'($urandom_range(7)),
                          1'b0);
            end
            send_word(pick_data(), 3'($urandom_range(7)), 1'b1);
            sent    += len;
            msg_idx += 1;
        end
        quiet = 1'b0;
    endtask

    // Stall the digest side at random, except during the quiet stretch.
    always @(posedge clk)
    begin
        dig_ch.ready <= quiet || ($urandom_range(99) >= IDLE_PCT);
    end

    // Check each accepted digest word against the oldest expectation.
    always @(posedge clk)
    begin
        digest_t exp_d;
        if (rst_n && dig_ch.valid && dig_ch.ready)
        begin
            if (digest_queue.size() == 0)
            begin
                $display("%0t: unexpected digest word: actual %h index %0d last %b",
                         $time, dig_ch.digest_word, dig_ch.digest_index, dig_ch.last_word);
                errors++;
            end
            else
            begin
                exp_d = digest_queue.pop_front();
                if (dig_ch.digest_word !== exp_d.word)
                begin
                    $display("%0t: digest_word mismatch: expected %h actual %h",
                             $time, exp_d.word, dig_ch.digest_word);
                    errors++;
                end
                if (dig_ch.digest_index !== exp_d.index)
                begin
                    $display("%0t: digest_index mismatch: expected %0d actual %0d",
                             $time, exp_d.index, dig_ch.digest_index);
                    errors++;
                end
                if (dig_ch.last_word !== exp_d.tail)
                begin
                    $display("%0t: last_word mismatch: expected %b actual %b",
                             $time, exp_d.tail, dig_ch.last_word);
                    errors++;
                end
            end
        end
    end

    initial
    begin
        int waited;
        // Drive every input to a known value before the first edge.
        msg_ch.valid       = 1'b0;
        msg_ch.data_word   = '0;
        msg_ch.valid_bytes = 3'd4;
        msg_ch.last        = 1'b0;
        dig_ch.ready       = 1'b0;
        sha1_restart();

        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_empty_message();
        test_final_byte_counts();
        test_ignored_byte_counts();
        test_short_text();
        test_random_messages();

        // Drop valid on the step of the final acceptance.
        msg_ch.valid <= 1'b0;

        // Drain outstanding digests, then allow for trailing activity.
        waited = 0;
        while ((digest_queue.size() != 0) && (waited < WAIT_LIMIT))
        begin
            @(posedge clk);
            waited++;
        end
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (digest_queue.size() != 0)
        begin
            $display("%0t: %0d digest words never arrived, next expected %h",
                     $time, digest_queue.size(), digest_queue[0].word);
            errors++;
        end

        if (errors == 0)
        begin
            $display("tb_sha1_hash_core passed");
        end
        else
        begin
            $display("tb_sha1_hash_core failed");
        end
        $finish;
    end

    // Hard stop well past the slowest legal run.
    initial
    begin
        #5ms;
        $display("tb_sha1_hash_core failed");
        $finish;
    end

endmodule

>>> sha1_hash_core.f
hw/rtl/sha1_pkg.sv
hw/rtl/sha1_channels.sv
hw/rtl/sha1_sched.sv
hw/rtl/sha1_round.sv
hw/rtl/sha1_hash_core.sv
hw/rtl/sha1_chk.sv
verif/tb_sha1_hash_core.sv
